// ===== rtl/core/vid_pkg.sv =====
// Package for the vertex index deduplication block.
// Holds the table sizing constants, field widths and the table entry type.
// Used by vid_hash, the top level and the checker; depends on nothing.
`default_nettype none

package vid_pkg;

   localparam int TABLE_DEPTH = 1024;
   localparam int ADDR_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int COUNT_W     = $clog2(TABLE_DEPTH + 1);
   localparam int FIELD_W     = 16;
   localparam int KEY_W       = 2 * FIELD_W;
   localparam int VNUM_W      = 10;
   localparam logic [FIELD_W-1:0] HASH_MULT = 16'h9e37;

   typedef logic [FIELD_W-1:0] field_type;
   typedef logic [KEY_W-1:0]   key_type;
   typedef logic [ADDR_W-1:0]  addr_type;
   typedef logic [COUNT_W-1:0] count_type;
   typedef logic [VNUM_W-1:0]  vnum_type;

   typedef struct packed {
      logic     valid;
      key_type  key;
      addr_type vnum;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

endpackage

`default_nettype wire

// ===== rtl/core/vid_ram.sv =====
// Generic single-port synchronous RAM with a registered read port.
// The read data holds its value on cycles without a read.
// Depends on nothing.
`default_nettype none

module vid_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                             clock,
   input  wire logic                             rd_en,
   input  wire logic                             wr_en,
   input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] addr,
   input  wire logic [WIDTH-1:0]                 wdata,
   output      logic [WIDTH-1:0]                 rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wdata;
      end
      if (rd_en) begin
         rdata_ff <= mem[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

// ===== rtl/core/vid_hash.sv =====
// Home slot hash for the deduplication table.
// Folds a 32-bit corner key into a registered table address.
// Depends on vid_pkg.
`default_nettype none

module vid_hash
   import vid_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      load,
   input  wire field_type position_index,
   input  wire field_type texcoord_index,
   output      addr_type  home
);

   field_type            prod;
   logic [31:0]          wide;
   logic [31:0]          shifted;
   addr_type             folded;
   addr_type             home_in;
   addr_type             home_ff;

   always_comb begin
      prod    = texcoord_index * HASH_MULT;
      wide    = {16'b0, position_index ^ prod};
      shifted = wide >> ADDR_W;
      folded  = wide[ADDR_W-1:0] ^ shifted[ADDR_W-1:0];
      if ({1'b0, folded} >= (ADDR_W + 1)'(TABLE_DEPTH)) begin
         home_in = folded - ADDR_W'(TABLE_DEPTH);
      end else begin
         home_in = folded;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         home_ff <= home_in;
      end
   end

   assign home = home_ff;

endmodule

`default_nettype wire

// ===== rtl/core/vertex_index_dedup_top.sv =====
// Top level of the vertex index deduplication block.
// Instantiates the key hash and the table RAM and runs the probe sequencer.
// Depends on vid_pkg, vid_hash and vid_ram.
`default_nettype none

// Each item is a triangle corner. Its key is looked up in a hashed table with
// linear probing held in one single-port RAM of TABLE_DEPTH entries. After
// acceptance the home slot is registered, then each probe is one RAM read and
// one compare of a table slot; the result is registered when a probe hits,
// finds an empty slot or was the last, and the next corner is accepted only
// after that. A miss on a full table probes every slot. One corner is in work
// at a time; a new corner is accepted while the previous result waits on
// rsp_stall, and a finished lookup waits for as long as that result is still
// stalled. After reset the block clears all TABLE_DEPTH table entries and
// holds req_stall high meanwhile.
module vertex_index_dedup_top
   import vid_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      req_valid,
   output      logic      req_stall,
   input  wire field_type req_position_index,
   input  wire field_type req_texcoord_index,
   output      logic      rsp_valid,
   input  wire logic      rsp_stall,
   output      vnum_type  rsp_vertex_number,
   output      logic      rsp_is_new,
   output      logic      rsp_table_full,
   output      field_type rsp_new_position_index,
   output      field_type rsp_new_texcoord_index
);

   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_HASH  = 3'd2;
   localparam logic [2:0] ST_PROBE = 3'd3;
   localparam logic [2:0] ST_CHECK = 3'd4;

   function automatic vnum_type to_vnum(input addr_type v);
      logic [VNUM_W+ADDR_W-1:0] tmp;
      tmp = {{VNUM_W{1'b0}}, v};
      return tmp[VNUM_W-1:0];
   endfunction

   logic [2:0] state_ff, state_in;
   addr_type   clr_ff, clr_in;
   addr_type   probe_ff, probe_in;
   addr_type   probes_ff, probes_in;
   count_type  count_ff, count_in;
   field_type  pos_ff, tex_ff;
   logic       rsp_valid_ff, rsp_valid_in;
   vnum_type   rsp_vnum_ff, rsp_vnum_in;
   logic       rsp_new_ff, rsp_new_in;
   logic       rsp_full_ff, rsp_full_in;
   field_type  rsp_pos_ff, rsp_pos_in;
   field_type  rsp_tex_ff, rsp_tex_in;

   logic               req_take;
   logic               slot_free;
   addr_type           home;
   logic               ram_rd_en;
   logic               ram_wr_en;
   addr_type           ram_addr;
   entry_type          wr_entry;
   logic [ENTRY_W-1:0] ram_rdata;
   entry_type          rd_entry;
   key_type            key;
   logic               hit, empty, last, done;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign key       = {tex_ff, pos_ff};
   assign rd_entry  = entry_type'(ram_rdata);
   assign hit       = rd_entry.valid && (rd_entry.key == key);
   assign empty     = !rd_entry.valid;
   assign last      = (probes_ff == ADDR_W'(TABLE_DEPTH - 1));
   assign done      = hit || empty || last;

   vid_hash u_hash (
      .clock          (clock),
      .load           (req_take),
      .position_index (req_position_index),
      .texcoord_index (req_texcoord_index),
      .home           (home)
   );

   vid_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (TABLE_DEPTH)
   ) u_ram (
      .clock (clock),
      .rd_en (ram_rd_en),
      .wr_en (ram_wr_en),
      .addr  (ram_addr),
      .wdata (wr_entry),
      .rdata (ram_rdata)
   );

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      probe_in     = probe_ff;
      probes_in    = probes_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_vnum_in  = rsp_vnum_ff;
      rsp_new_in   = rsp_new_ff;
      rsp_full_in  = rsp_full_ff;
      rsp_pos_in   = rsp_pos_ff;
      rsp_tex_in   = rsp_tex_ff;
      ram_rd_en    = 1'b0;
      ram_wr_en    = 1'b0;
      ram_addr     = probe_ff;
      wr_entry     = '{valid: 1'b1, key: key, vnum: count_ff[ADDR_W-1:0]};
      unique case (state_ff)
         ST_CLEAR: begin
            ram_wr_en = 1'b1;
            ram_addr  = clr_ff;
            wr_entry  = '0;
            clr_in    = clr_ff + 1'b1;
            if (clr_ff == ADDR_W'(TABLE_DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_take) begin
               state_in = ST_HASH;
            end
         end
         ST_HASH: begin
            probe_in  = home;
            probes_in = '0;
            state_in  = ST_PROBE;
         end
         ST_PROBE: begin
            ram_rd_en = 1'b1;
            state_in  = ST_CHECK;
         end
         ST_CHECK: begin
            if (!done) begin
               probe_in  = (probe_ff == ADDR_W'(TABLE_DEPTH - 1)) ? '0 : probe_ff + 1'b1;
               probes_in = probes_ff + 1'b1;
               state_in  = ST_PROBE;
            end else if (slot_free) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
               rsp_vnum_in  = '0;
               rsp_new_in   = 1'b0;
               rsp_full_in  = 1'b0;
               rsp_pos_in   = '0;
               rsp_tex_in   = '0;
               priority if (hit) begin
                  rsp_vnum_in = to_vnum(rd_entry.vnum);
               end else if (empty) begin
                  ram_wr_en   = 1'b1;
                  count_in    = count_ff + 1'b1;
                  rsp_vnum_in = to_vnum(count_ff[ADDR_W-1:0]);
                  rsp_new_in  = 1'b1;
                  rsp_pos_in  = pos_ff;
                  rsp_tex_in  = tex_ff;
               end else begin
                  rsp_full_in = 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      probe_ff    <= probe_in;
      probes_ff   <= probes_in;
      rsp_vnum_ff <= rsp_vnum_in;
      rsp_new_ff  <= rsp_new_in;
      rsp_full_ff <= rsp_full_in;
      rsp_pos_ff  <= rsp_pos_in;
      rsp_tex_ff  <= rsp_tex_in;
      if (req_take) begin
         pos_ff <= req_position_index;
         tex_ff <= req_texcoord_index;
      end
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_vertex_number      = rsp_vnum_ff;
   assign rsp_is_new             = rsp_new_ff;
   assign rsp_table_full         = rsp_full_ff;
   assign rsp_new_position_index = rsp_pos_ff;
   assign rsp_new_texcoord_index = rsp_tex_ff;

endmodule

`default_nettype wire

// ===== rtl/core/vid_checker.sv =====
// Port-level checker for the vertex index deduplication block.
// Watches the top level's ports and is bound to vertex_index_dedup_top.
// Depends on vid_pkg.
`default_nettype none

module vid_checker
   import vid_pkg::*;
(
   input wire logic      clock,
   input wire logic      reset,
   input wire logic      req_valid,
   input wire logic      req_stall,
   input wire logic      rsp_valid,
   input wire logic      rsp_stall,
   input wire vnum_type  rsp_vertex_number,
   input wire logic      rsp_is_new,
   input wire logic      rsp_table_full,
   input wire field_type rsp_new_position_index,
   input wire field_type rsp_new_texcoord_index
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_vertex_number)
         && $stable(rsp_is_new) && $stable(rsp_table_full)
         && $stable(rsp_new_position_index) && $stable(rsp_new_texcoord_index))
      else $error("Stalled result item changed.");

   a_full_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_table_full |-> !rsp_is_new && (rsp_vertex_number == '0))
      else $error("Table-full result carries a vertex.");

   a_hit_echo: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_is_new |->
         (rsp_new_position_index == '0) && (rsp_new_texcoord_index == '0))
      else $error("Echoed indices set on an item that is not new.");

   a_one_in_work: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("Second item accepted while one is in work.");

endmodule

bind vertex_index_dedup_top vid_checker u_vid_checker (
   .clock                  (clock),
   .reset                  (reset),
   .req_valid              (req_valid),
   .req_stall              (req_stall),
   .rsp_valid              (rsp_valid),
   .rsp_stall              (rsp_stall),
   .rsp_vertex_number      (rsp_vertex_number),
   .rsp_is_new             (rsp_is_new),
   .rsp_table_full         (rsp_table_full),
   .rsp_new_position_index (rsp_new_position_index),
   .rsp_new_texcoord_index (rsp_new_texcoord_index)
);

`default_nettype wire
